### sv/rgbxyz_pkg.sv
package rgbxyz_pkg;

  localparam int unsigned IN_CURVE_DEPTH  = 4096;
  localparam int unsigned OUT_CURVE_DEPTH = 4096;
  localparam int unsigned IN_AW  = $clog2(IN_CURVE_DEPTH);
  localparam int unsigned OUT_AW = $clog2(OUT_CURVE_DEPTH);
  localparam int unsigned MAT_N  = 9;
  localparam int unsigned SCALE_SHIFT = 45;
  localparam logic [15:0] GAIN_RESET = 16'd60068;
  localparam logic [34:0] ONE_Q29 = 35'd1 << 29;
  localparam int unsigned OUT_Q_DEPTH = 8;
  localparam int unsigned OUT_Q_CW = $clog2(OUT_Q_DEPTH) + 1;

  typedef enum logic [1:0] {
    CMD_PIXEL  = 2'd0,
    CMD_WR_IN  = 2'd1,
    CMD_WR_OUT = 2'd2,
    CMD_WR_MAT = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] red_code;
    logic [11:0] green_code;
    logic [11:0] blue_code;
    logic        frame_end;
    logic [11:0] table_address;
    logic [15:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] x_code;
    logic [11:0] y_code;
    logic [11:0] z_code;
    logic        frame_last;
  } out_item_t;

  typedef struct packed {
    logic             is_pix;
    logic             wr_in;
    logic             wr_out;
    logic             wr_mat;
    logic             frame;
    logic [IN_AW-1:0] r_addr;
    logic [IN_AW-1:0] g_addr;
    logic [IN_AW-1:0] b_addr;
    logic [11:0]      tab_addr;
    logic [15:0]      tab_val;
  } op_t;

  function automatic logic [IN_AW-1:0] sat_in(input logic [11:0] code);
    logic [16:0] ext;
    ext = 17'(code);
    if (ext >= 17'(IN_CURVE_DEPTH)) begin
      return IN_AW'(IN_CURVE_DEPTH - 1);
    end
    return IN_AW'(code);
  endfunction

endpackage

### sv/rgbxyz_front.sv
module rgbxyz_front
  import rgbxyz_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output op_t      op_o
);

  localparam int unsigned QD = 4;

  op_t        q_mem [QD];
  logic [1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  op_t        cls;

  always_comb begin
    cls          = '0;
    cls.is_pix   = item_i.command == CMD_PIXEL;
    cls.wr_in    = (item_i.command == CMD_WR_IN) &&
                   (17'(item_i.table_address) < 17'(IN_CURVE_DEPTH));
    cls.wr_out   = (item_i.command == CMD_WR_OUT) &&
                   (17'(item_i.table_address) < 17'(OUT_CURVE_DEPTH));
    cls.wr_mat   = (item_i.command == CMD_WR_MAT) &&
                   (item_i.table_address < 12'(MAT_N));
    cls.frame    = item_i.frame_end;
    cls.r_addr   = sat_in(item_i.red_code);
    cls.g_addr   = sat_in(item_i.green_code);
    cls.b_addr   = sat_in(item_i.blue_code);
    cls.tab_addr = item_i.table_address;
    cls.tab_val  = item_i.table_value;
  end

  assign full_o  = cnt_q == 3'(QD);
  assign valid_o = cnt_q != 3'd0;
  assign op_o    = q_mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + 2'(do_push);
    rd_ptr_d = rd_ptr_q + 2'(do_pop);
    cnt_d    = cnt_q + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### sv/rgbxyz_back.sv
module rgbxyz_back
  import rgbxyz_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         gain_i,
  input  logic                valid_i,
  input  op_t                 op_i,
  output logic                pop_o,
  input  logic [OUT_Q_CW-1:0] out_cnt_i,
  output logic                push_o,
  output out_item_t           item_o
);

  logic [15:0] in_r [IN_CURVE_DEPTH];
  logic [15:0] in_g [IN_CURVE_DEPTH];
  logic [15:0] in_b [IN_CURVE_DEPTH];
  logic [11:0] oc_x [OUT_CURVE_DEPTH];
  logic [11:0] oc_y [OUT_CURVE_DEPTH];
  logic [11:0] oc_z [OUT_CURVE_DEPTH];
  logic [15:0] mat_q [MAT_N];

  logic               a_pix_q, b_pix_q, c_pix_q, d_pix_q, e_pix_q, f_pix_q;
  logic               a_wo_q, b_wo_q, c_wo_q, d_wo_q, e_wo_q;
  logic               a_fr_q, b_fr_q, c_fr_q, d_fr_q, e_fr_q, f_fr_q;
  logic [11:0]        a_wa_q, b_wa_q, c_wa_q, d_wa_q, e_wa_q;
  logic [11:0]        a_wv_q, b_wv_q, c_wv_q, d_wv_q, e_wv_q;
  logic [15:0]        lin_q [3];
  logic [15:0]        a_mat_q [MAT_N];
  logic signed [32:0] prod_d [MAT_N];
  logic signed [32:0] prod_q [MAT_N];
  logic [34:0]        sum_d [3];
  logic [34:0]        sum_q [3];
  logic [29:0]        clamp [3];
  logic [45:0]        sc_q [3];
  logic [45+OUT_AW:0] big [3];
  logic [OUT_AW-1:0]  idx_q [3];
  logic [11:0]        f_x_q, f_y_q, f_z_q;
  logic [2:0]         inflight;
  logic [OUT_Q_CW:0]  used;
  logic [IN_AW-1:0]   in_wa;
  logic [OUT_AW-1:0]  out_wa;

  assign inflight = 3'($countones({a_pix_q, b_pix_q, c_pix_q, d_pix_q, e_pix_q, f_pix_q}));
  assign used     = (OUT_Q_CW+1)'(out_cnt_i) + (OUT_Q_CW+1)'(inflight);
  assign pop_o    = valid_i && (used < (OUT_Q_CW+1)'(OUT_Q_DEPTH));
  assign in_wa    = IN_AW'(op_i.tab_addr);
  assign out_wa   = OUT_AW'(e_wa_q);

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.wr_in) begin
      in_r[in_wa] <= op_i.tab_val;
      in_g[in_wa] <= op_i.tab_val;
      in_b[in_wa] <= op_i.tab_val;
    end
    if (pop_o && op_i.is_pix) begin
      lin_q[0] <= in_r[op_i.r_addr];
      lin_q[1] <= in_g[op_i.g_addr];
      lin_q[2] <= in_b[op_i.b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.wr_mat) begin
      mat_q[op_i.tab_addr[3:0]] <= op_i.tab_val;
    end
    if (pop_o && op_i.is_pix) begin
      a_mat_q <= mat_q;
    end
  end

  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      prod_d[i] = $signed({1'b0, lin_q[i % 3]}) * $signed(a_mat_q[i]);
    end
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = 35'(prod_q[3*r]) + 35'(prod_q[3*r+1]) + 35'(prod_q[3*r+2]);
      if (sum_q[r][34]) begin
        clamp[r] = '0;
      end else if (sum_q[r] > ONE_Q29) begin
        clamp[r] = ONE_Q29[29:0];
      end else begin
        clamp[r] = sum_q[r][29:0];
      end
      big[r] = (46+OUT_AW)'(sc_q[r]) * (46+OUT_AW)'(OUT_CURVE_DEPTH - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    a_fr_q <= op_i.frame;
    a_wa_q <= op_i.tab_addr;
    a_wv_q <= op_i.tab_val[11:0];
    b_fr_q <= a_fr_q;  b_wa_q <= a_wa_q;  b_wv_q <= a_wv_q;
    c_fr_q <= b_fr_q;  c_wa_q <= b_wa_q;  c_wv_q <= b_wv_q;
    d_fr_q <= c_fr_q;  d_wa_q <= c_wa_q;  d_wv_q <= c_wv_q;
    e_fr_q <= d_fr_q;  e_wa_q <= d_wa_q;  e_wv_q <= d_wv_q;
    f_fr_q <= e_fr_q;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    for (int r = 0; r < 3; r++) begin
      sc_q[r]  <= 46'(clamp[r]) * 46'(gain_i);
      idx_q[r] <= big[r][SCALE_SHIFT +: OUT_AW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_wo_q) begin
      oc_x[out_wa] <= e_wv_q;
      oc_y[out_wa] <= e_wv_q;
      oc_z[out_wa] <= e_wv_q;
    end
    if (e_pix_q) begin
      f_x_q <= oc_x[idx_q[0]];
      f_y_q <= oc_y[idx_q[1]];
      f_z_q <= oc_z[idx_q[2]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_pix_q <= 1'b0; b_pix_q <= 1'b0; c_pix_q <= 1'b0;
      d_pix_q <= 1'b0; e_pix_q <= 1'b0; f_pix_q <= 1'b0;
      a_wo_q  <= 1'b0; b_wo_q  <= 1'b0; c_wo_q  <= 1'b0;
      d_wo_q  <= 1'b0; e_wo_q  <= 1'b0;
    end else begin
      a_pix_q <= pop_o && op_i.is_pix;
      a_wo_q  <= pop_o && op_i.wr_out;
      b_pix_q <= a_pix_q; c_pix_q <= b_pix_q; d_pix_q <= c_pix_q;
      e_pix_q <= d_pix_q; f_pix_q <= e_pix_q;
      b_wo_q  <= a_wo_q;  c_wo_q  <= b_wo_q;  d_wo_q  <= c_wo_q;
      e_wo_q  <= d_wo_q;
    end
  end

  assign push_o            = f_pix_q;
  assign item_o.x_code     = f_x_q;
  assign item_o.y_code     = f_y_q;
  assign item_o.z_code     = f_z_q;
  assign item_o.frame_last = f_fr_q;

endmodule

### sv/rgbxyz_out_fifo.sv
module rgbxyz_out_fifo
  import rgbxyz_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  out_item_t           item_i,
  input  logic                pop_i,
  output logic                empty_o,
  output out_item_t           item_o,
  output logic [OUT_Q_CW-1:0] cnt_o
);

  localparam int unsigned PW = $clog2(OUT_Q_DEPTH);

  out_item_t           mem [OUT_Q_DEPTH];
  logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [OUT_Q_CW-1:0] cnt_q;
  logic                do_pop;

  assign empty_o = cnt_q == '0;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem[rd_ptr_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i);
      rd_ptr_q <= rd_ptr_q + PW'(do_pop);
      cnt_q    <= cnt_q + OUT_Q_CW'(push_i) - OUT_Q_CW'(do_pop);
    end
  end

endmodule

### sv/rgb_to_xyz_lut_matrix_convert_core.sv
// RGB to XYZ converter: input curve, 3x3 matrix, output curve. Takes one item
// per clock unless the front queue is full or the result queue lacks credit;
// a pixel's result enters the result queue from the last back stage, while
// table-load items give no result. A four-entry front queue classifies items,
// a six-stage back pipeline (curve read, products, sums, gain, index, output
// curve read) processes them, and an eight-entry result queue with credit
// from the back pipeline lets both sides stall independently.
module rgb_to_xyz_lut_matrix_convert_core
  import rgbxyz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  in_item_t    in_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]         gain_q;
  logic                q_valid, q_pop, b_push;
  op_t                 q_op;
  out_item_t           b_item;
  logic [OUT_Q_CW-1:0] out_cnt;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(gain_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      gain_q <= pwdata[15:0];
    end
  end

  rgbxyz_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_i),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  rgbxyz_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gain_i    (gain_q),
    .valid_i   (q_valid),
    .op_i      (q_op),
    .pop_o     (q_pop),
    .out_cnt_i (out_cnt),
    .push_o    (b_push),
    .item_o    (b_item)
  );

  rgbxyz_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_push),
    .item_i  (b_item),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (out_o),
    .cnt_o   (out_cnt)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(b_push && out_cnt == OUT_Q_CW'(OUT_Q_DEPTH)))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && q_op.is_pix |-> ##6 b_push)
    else $error("pixel lost in back pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty front queue");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import rgbxyz_pkg::*;

  class xyz_scoreboard;
    logic [15:0] lin_curve[IN_CURVE_DEPTH];
    logic [11:0] code_curve[OUT_CURVE_DEPTH];
    bit          in_set[IN_CURVE_DEPTH];
    bit          out_set[OUT_CURVE_DEPTH];
    logic [15:0] mat[MAT_N];
    logic [15:0] gain;
    out_item_t   pending_xyz[$];
    int          errors;

    function new();
      gain = GAIN_RESET;
      errors = 0;
      foreach (mat[k]) mat[k] = '0;
      foreach (in_set[k]) in_set[k] = 1'b0;
      foreach (out_set[k]) out_set[k] = 1'b0;
    endfunction

    function longint out_index(longint acc);
      longint scaled;
      longint idx;
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q29)) acc = longint'(ONE_Q29);
      scaled = acc * longint'(gain) * longint'(OUT_CURVE_DEPTH - 1);
      idx = scaled >>> SCALE_SHIFT;
      if (idx >= OUT_CURVE_DEPTH) idx = OUT_CURVE_DEPTH - 1;
      return idx;
    endfunction

    function longint row_sum(int row, logic [11:0] r, logic [11:0] g, logic [11:0] b);
      longint lin[3];
      longint acc;
      lin[0] = longint'(lin_curve[r]);
      lin[1] = longint'(lin_curve[g]);
      lin[2] = longint'(lin_curve[b]);
      acc = 0;
      for (int col = 0; col < 3; col++)
        acc += lin[col] * longint'($signed(mat[row*3+col]));
      return acc;
    endfunction

    function logic [11:0] compand(longint acc);
      return code_curve[out_index(acc)];
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [11:0] res[3];
      case (cmd_e'(it.command))
        CMD_WR_IN: begin
          lin_curve[it.table_address] = it.table_value;
          in_set[it.table_address] = 1'b1;
        end
        CMD_WR_OUT: begin
          code_curve[it.table_address] = it.table_value[11:0];
          out_set[it.table_address] = 1'b1;
        end
        CMD_WR_MAT: if (it.table_address < MAT_N) mat[it.table_address] = it.table_value;
        default: begin
          for (int row = 0; row < 3; row++)
            res[row] = compand(row_sum(row, it.red_code, it.green_code, it.blue_code));
          r.x_code = res[0];
          r.y_code = res[1];
          r.z_code = res[2];
          r.frame_last = it.frame_end;
          pending_xyz.push_back(r);
        end
      endcase
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_xyz.size() == 0) begin
        report("unexpected item", 1, 0);
        return;
      end
      want = pending_xyz.pop_front();
      if (got.x_code !== want.x_code) report("x_code", got.x_code, want.x_code);
      if (got.y_code !== want.y_code) report("y_code", got.y_code, want.y_code);
      if (got.z_code !== want.z_code) report("z_code", got.z_code, want.z_code);
      if (got.frame_last !== want.frame_last)
        report("frame_last", got.frame_last, want.frame_last);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  in_item_t    in_i;
  logic        full;
  logic        empty;
  logic        pop;
  out_item_t   out_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  xyz_scoreboard sb = new();
  bit quiet;
  int hold_cycles;
  int code_pool[64];

  rgb_to_xyz_lut_matrix_convert_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #16_000_000;
    $display("FAIL rgb_to_xyz_lut_matrix_convert_core");
    $finish;
  end

  task send(in_item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
  endtask

  task load(cmd_e cmd, int addr, int value);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
    it.command = cmd;
    it.table_address = 12'(addr);
    it.table_value = 16'(value);
    send(it);
  endtask

  task pixel(int r, int g, int b, bit fe);
    in_item_t it;
    int codes[3];
    longint idx;
    codes[0] = r;
    codes[1] = g;
    codes[2] = b;
    for (int c = 0; c < 3; c++)
      if (!sb.in_set[codes[c]]) load(CMD_WR_IN, codes[c], $urandom_range(0, 65535));
    for (int row = 0; row < 3; row++) begin
      idx = sb.out_index(sb.row_sum(row, 12'(r), 12'(g), 12'(b)));
      if (!sb.out_set[idx]) load(CMD_WR_OUT, int'(idx), $urandom_range(0, 65535));
    end
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
    it.command = CMD_PIXEL;
    it.red_code = 12'(r);
    it.green_code = 12'(g);
    it.blue_code = 12'(b);
    it.frame_end = fe;
    send(it);
  endtask

  task drain();
    push <= 1'b0;
    while (sb.pending_xyz.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_gain(logic [15:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'd0;
    pwdata <= {16'($urandom_range(0, 65535)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.gain = value;
  endtask

  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_o);
    end
  end

  task random_phase(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) load(CMD_WR_IN, $urandom_range(0, 4095), $urandom_range(0, 65535));
      else if (mode == 1) load(CMD_WR_OUT, $urandom_range(0, 4095), $urandom_range(0, 65535));
      else if (mode == 2) load(CMD_WR_MAT, $urandom_range(0, 15), $urandom_range(0, 65535));
      else if (mode == 3) load(CMD_WR_MAT, $urandom_range(0, 8), $urandom_range(0, 24576));
      else pixel(code_pool[$urandom_range(0, 63)], code_pool[$urandom_range(0, 63)],
                 code_pool[$urandom_range(0, 63)], $urandom_range(0, 1));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    in_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    hold_cycles = 0;
    code_pool[0] = 0;
    code_pool[1] = 4095;
    for (int k = 2; k < 64; k++) code_pool[k] = $urandom_range(0, 4095);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < MAT_N; k++) load(CMD_WR_MAT, k, (k % 4 == 0) ? 16384 : 0);

    load(CMD_WR_IN, 0, 0);
    load(CMD_WR_IN, 4095, 65535);
    load(CMD_WR_OUT, 4095, 65535);
    load(CMD_WR_OUT, 0, 0);
    pixel(0, 0, 0, 1'b0);
    pixel(4095, 4095, 4095, 1'b1);
    pixel(4095, 0, 2048, 1'b0);
    load(CMD_WR_MAT, 9, 16'h7fff);
    load(CMD_WR_MAT, 4095, 16'h8000);
    pixel(4095, 4095, 4095, 1'b1);
    load(CMD_WR_MAT, 1, 16'h8000);
    load(CMD_WR_MAT, 3, 16'h7fff);
    load(CMD_WR_MAT, 8, 16'hc000);
    pixel(4095, 4095, 4095, 1'b0);
    pixel(1234, 3000, 17, 1'b1);
    pixel(0, 4095, 0, 1'b0);
    drain();

    write_gain(16'd0);
    random_phase(150);
    hold_cycles = 300;
    random_phase(60);
    drain();

    write_gain(16'hffff);
    random_phase(120);
    drain();

    write_gain(16'($urandom_range(1, 65534)));
    random_phase(120);
    drain();

    write_gain(GAIN_RESET);
    quiet = 1'b1;
    random_phase(120);
    drain();

    if (sb.errors == 0) begin
      $display("PASS rgb_to_xyz_lut_matrix_convert_core");
    end else begin
      $display("FAIL rgb_to_xyz_lut_matrix_convert_core");
    end
    $finish;
  end

endmodule
